[hw/rtl/u8norm_pkg.sv]
// ----------------------------------------------------------------------------
// u8norm_pkg
// Shared types, constants and byte classification functions for the UTF-8
// text width and sign normalizer.
// ----------------------------------------------------------------------------
package u8norm_pkg;

    localparam int OUT_DEPTH = 4;

    localparam logic [7:0]  LEAD_MASK     = 8'hF0;
    localparam logic [7:0]  LEAD_3B       = 8'hE0;
    localparam logic [7:0]  CONT_MASK     = 8'h3F;
    localparam logic [15:0] CP_IDEO_SPACE = 16'h3000;
    localparam logic [15:0] CP_FW_FIRST   = 16'hFF01;
    localparam logic [15:0] CP_FW_LAST    = 16'hFF5E;
    localparam logic [15:0] CP_FW_OFFSET  = 16'hFEE0;
    localparam logic [15:0] CP_SMALL_LOW  = 16'hFE4F;
    localparam logic [15:0] CP_HW_FIRST   = 16'hFF5F;
    localparam logic [15:0] CP_HW_LAST    = 16'hFF64;
    localparam logic [7:0]  SPACE         = 8'h20;

    localparam int SIGN_COUNT = 35;

    localparam logic [15:0] SIGN_TABLE [SIGN_COUNT] = '{
        16'h2013, 16'h2014, 16'h2018, 16'h2019, 16'h201B, 16'h201C, 16'h201D,
        16'h201E, 16'h201F, 16'h2026, 16'h3001, 16'h3002, 16'h3003, 16'h300B,
        16'h300C, 16'h300D, 16'h300E, 16'h300F, 16'h3010, 16'h3011, 16'h3014,
        16'h3015, 16'h3016, 16'h3017, 16'h3018, 16'h3019, 16'h301A, 16'h301B,
        16'h301C, 16'h301D, 16'h301E, 16'h301F, 16'h3030, 16'h303E, 16'h303F
    };

    typedef struct packed {
        logic [2:0][7:0] bytes;
        logic [1:0]      cnt;
        logic            last;
        logic            no_byte;
    } grp_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_stat_t;

    function automatic logic is_sign_cp(input logic [15:0] cp);
        logic hit;
        hit = (cp == CP_SMALL_LOW) || (cp >= CP_HW_FIRST && cp <= CP_HW_LAST);
        for (int i = 0; i < SIGN_COUNT; i++) begin
            if (cp == SIGN_TABLE[i]) begin
                hit = 1'b1;
            end
        end
        return hit;
    endfunction

    function automatic logic is_ascii_sign(input logic [7:0] b);
        return (b inside {[8'h21:8'h2C], 8'h2F, [8'h3B:8'h40], [8'h5B:8'h60],
                          [8'h7B:8'h7E]});
    endfunction

    function automatic logic [7:0] norm_byte(input logic [7:0] b);
        logic ws;
        ws = (b == SPACE) || (b inside {[8'h09:8'h0D]});
        return (ws || is_ascii_sign(b)) ? SPACE : b;
    endfunction

endpackage

[hw/rtl/u8norm_out_queue.sv]
// ----------------------------------------------------------------------------
// u8norm_out_queue
// Queue of result groups (one to three bytes each) that unloads one byte
// per cycle onto the result channel while m_ready is high.
// ----------------------------------------------------------------------------
module u8norm_out_queue #(
    parameter int DEPTH = u8norm_pkg::OUT_DEPTH
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                push,
    input  u8norm_pkg::grp_t    push_data,
    output u8norm_pkg::q_stat_t stat,
    output logic                m_valid,
    input  logic                m_ready,
    output logic [7:0]          m_out_byte,
    output logic                m_last,
    output logic                m_no_byte
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_MAX = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    u8norm_pkg::grp_t mem_reg [DEPTH];

    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [1:0]       idx_reg, idx_next;

    u8norm_pkg::grp_t head;
    logic             last_in_grp;
    logic             pop_byte;
    logic             pop_grp;

    assign head        = mem_reg[rd_ptr_reg];
    assign stat.full   = (count_reg == CNT_FULL);
    assign stat.empty  = (count_reg == '0);
    assign m_valid     = !stat.empty;
    assign m_out_byte  = head.bytes[idx_reg];
    assign last_in_grp = (idx_reg == head.cnt - 2'd1);
    assign m_last      = head.last && last_in_grp;
    assign m_no_byte   = head.no_byte;
    assign pop_byte    = m_valid && m_ready;
    assign pop_grp     = pop_byte && last_in_grp;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        idx_next    = idx_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_MAX) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop_byte) begin
            idx_next = last_in_grp ? 2'd0 : idx_reg + 2'd1;
        end
        if (pop_grp) begin
            rd_ptr_next = (rd_ptr_reg == PTR_MAX) ? '0 : rd_ptr_reg + 1'b1;
        end
        case ({push, pop_grp})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
            idx_reg    <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
            idx_reg    <= idx_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

[hw/rtl/utf8_text_width_and_sign_normalizer.sv]
// ----------------------------------------------------------------------------
// utf8_text_width_and_sign_normalizer
// Maps fullwidth forms and CJK signs in a UTF-8 byte stream to ASCII or
// space, turns ASCII punctuation into space and collapses whitespace runs.
// ----------------------------------------------------------------------------
// Takes one input byte per cycle unless the queue is full, and gives one
// result byte per cycle while m_ready is high. An accepted item waits in the
// input register, is decoded in a single pass against the held group bytes,
// and its results (none to three bytes) enter the output queue as one group;
// the earliest result is offered once its group is queued. Raw three-byte
// groups unload one byte at a time; the queue holds OUT_DEPTH groups, which
// sets how long a stall on the result side is absorbed before s_ready drops.
// The last result of each string carries m_last; a string that ends with
// nothing to emit yields one result with m_no_byte set and m_out_byte zero.
module utf8_text_width_and_sign_normalizer #(
    parameter int OUT_DEPTH = u8norm_pkg::OUT_DEPTH
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_in_byte,
    input  logic       s_end_of_string,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [7:0] m_out_byte,
    output logic       m_last,
    output logic       m_no_byte
);

    logic       in_vld_reg, in_vld_next;
    logic [7:0] in_byte_reg;
    logic       in_eos_reg;

    logic [7:0] held0_reg, held0_next;
    logic [7:0] held1_reg, held1_next;
    logic [1:0] held_count_reg, held_count_next;
    logic       prev_space_reg, prev_space_next;

    u8norm_pkg::q_stat_t q_stat;
    u8norm_pkg::grp_t    push_data;
    logic                push;
    logic                s_fire;
    logic                in_fire;

    logic [15:0]     cp;
    logic [7:0]      cand [3];
    logic [1:0]      cand_n;
    logic [7:0]      fb [3];
    logic [2:0][7:0] obytes;
    logic [1:0]      k;
    logic            prev_c;

    assign s_ready = !in_vld_reg || !q_stat.full;
    assign s_fire  = s_valid && s_ready;
    assign in_fire = in_vld_reg && !q_stat.full;

    assign cp = {held0_reg[3:0], held1_reg[5:0] & u8norm_pkg::CONT_MASK[5:0],
                 in_byte_reg[5:0] & u8norm_pkg::CONT_MASK[5:0]};

    always_comb begin
        held0_next      = held0_reg;
        held1_next      = held1_reg;
        held_count_next = held_count_reg;
        cand[0]         = 8'h00;
        cand[1]         = 8'h00;
        cand[2]         = 8'h00;
        cand_n          = 2'd0;
        case (held_count_reg)
            2'd0: begin
                if ((in_byte_reg & u8norm_pkg::LEAD_MASK) == u8norm_pkg::LEAD_3B
                        && !in_eos_reg) begin
                    held0_next      = in_byte_reg;
                    held_count_next = 2'd1;
                end else begin
                    cand[0] = in_byte_reg;
                    cand_n  = 2'd1;
                end
            end
            2'd1: begin
                if (!in_eos_reg) begin
                    held1_next      = in_byte_reg;
                    held_count_next = 2'd2;
                end else begin
                    cand[0]         = held0_reg;
                    cand[1]         = in_byte_reg;
                    cand_n          = 2'd2;
                    held_count_next = 2'd0;
                end
            end
            default: begin
                held_count_next = 2'd0;
                if (cp == u8norm_pkg::CP_IDEO_SPACE) begin
                    cand[0] = u8norm_pkg::SPACE;
                    cand_n  = 2'd1;
                end else if (cp >= u8norm_pkg::CP_FW_FIRST
                             && cp <= u8norm_pkg::CP_FW_LAST) begin
                    cand[0] = 8'(cp - u8norm_pkg::CP_FW_OFFSET);
                    cand_n  = 2'd1;
                end else if (u8norm_pkg::is_sign_cp(cp)) begin
                    cand[0] = u8norm_pkg::SPACE;
                    cand_n  = 2'd1;
                end else begin
                    cand[0] = held0_reg;
                    cand[1] = held1_reg;
                    cand[2] = in_byte_reg;
                    cand_n  = 2'd3;
                end
            end
        endcase
        if (in_eos_reg) begin
            held_count_next = 2'd0;
        end
    end

    // Filter and collapse spaces, packing kept bytes to the front.
    always_comb begin
        obytes = '0;
        k      = 2'd0;
        prev_c = prev_space_reg;
        for (int i = 0; i < 3; i++) begin
            fb[i] = u8norm_pkg::norm_byte(cand[i]);
            if (2'(i) < cand_n) begin
                if (!(fb[i] == u8norm_pkg::SPACE && prev_c)) begin
                    obytes[k] = fb[i];
                    k         = k + 2'd1;
                    prev_c    = (fb[i] == u8norm_pkg::SPACE);
                end
            end
        end
        prev_space_next   = in_eos_reg ? 1'b0 : prev_c;
        push              = in_fire && ((k != 2'd0) || in_eos_reg);
        push_data.bytes   = obytes;
        push_data.cnt     = (k == 2'd0) ? 2'd1 : k;
        push_data.last    = in_eos_reg;
        push_data.no_byte = (k == 2'd0);
    end

    always_comb begin
        in_vld_next = in_vld_reg;
        if (s_fire) begin
            in_vld_next = 1'b1;
        end else if (in_fire) begin
            in_vld_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg     <= 1'b0;
            held0_reg      <= 8'h00;
            held1_reg      <= 8'h00;
            held_count_reg <= 2'd0;
            prev_space_reg <= 1'b0;
        end else begin
            in_vld_reg <= in_vld_next;
            if (in_fire) begin
                held0_reg      <= held0_next;
                held1_reg      <= held1_next;
                held_count_reg <= held_count_next;
                prev_space_reg <= prev_space_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            in_byte_reg <= s_in_byte;
            in_eos_reg  <= s_end_of_string;
        end
    end

    u8norm_out_queue #(
        .DEPTH(OUT_DEPTH)
    ) u_out_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_data (push_data),
        .stat      (q_stat),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_out_byte(m_out_byte),
        .m_last    (m_last),
        .m_no_byte (m_no_byte)
    );

`ifndef SYNTHESIS
    a_held_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        held_count_reg != 2'd3)
        else $error("held count out of range");

    a_eos_clears_state: assert property (@(posedge aclk) disable iff (!aresetn)
        in_fire && in_eos_reg |=> held_count_reg == 2'd0 && !prev_space_reg)
        else $error("end of string did not clear state");

    a_marker_only: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_no_byte |-> m_last && m_out_byte == 8'h00)
        else $error("marker-only result malformed");

    a_queue_stat: assert property (@(posedge aclk) disable iff (!aresetn)
        !(q_stat.full && q_stat.empty))
        else $error("queue both full and empty");
`endif

endmodule
